### rtl/core/rea_pkg.sv
// ----------------------------------------------------------------------------
// rea_pkg: shared types and codes for the execute-stage alu
// opcodes, function codes, alu operation enum and decoded control struct
// ----------------------------------------------------------------------------
package rea_pkg;

    localparam int unsigned DataWidth = 32;
    localparam int unsigned RegIdxWidth = 5;
    localparam int unsigned ImmWidth = 16;
    localparam int unsigned CodeWidth = 6;
    localparam int unsigned ShamtWidth = 5;

    // primary opcodes
    localparam logic [CodeWidth-1:0] OP_RTYPE = 6'h00;
    localparam logic [CodeWidth-1:0] OP_ADDI  = 6'h08;
    localparam logic [CodeWidth-1:0] OP_SLTI  = 6'h0A;
    localparam logic [CodeWidth-1:0] OP_ANDI  = 6'h0C;
    localparam logic [CodeWidth-1:0] OP_ORI   = 6'h0D;
    localparam logic [CodeWidth-1:0] OP_NORI  = 6'h0E;
    localparam logic [CodeWidth-1:0] OP_LUI   = 6'h0F;
    localparam logic [CodeWidth-1:0] OP_LB    = 6'h20;
    localparam logic [CodeWidth-1:0] OP_LH    = 6'h21;
    localparam logic [CodeWidth-1:0] OP_LW    = 6'h23;
    localparam logic [CodeWidth-1:0] OP_LBU   = 6'h24;
    localparam logic [CodeWidth-1:0] OP_LHU   = 6'h25;
    localparam logic [CodeWidth-1:0] OP_SB    = 6'h28;
    localparam logic [CodeWidth-1:0] OP_SH    = 6'h29;
    localparam logic [CodeWidth-1:0] OP_SW    = 6'h2B;

    // r-type function codes
    localparam logic [CodeWidth-1:0] FN_SLL  = 6'h00;
    localparam logic [CodeWidth-1:0] FN_SRL  = 6'h02;
    localparam logic [CodeWidth-1:0] FN_SRA  = 6'h03;
    localparam logic [CodeWidth-1:0] FN_JR   = 6'h08;
    localparam logic [CodeWidth-1:0] FN_ADD  = 6'h20;
    localparam logic [CodeWidth-1:0] FN_SUB  = 6'h22;
    localparam logic [CodeWidth-1:0] FN_AND  = 6'h24;
    localparam logic [CodeWidth-1:0] FN_OR   = 6'h25;
    localparam logic [CodeWidth-1:0] FN_XOR  = 6'h26;
    localparam logic [CodeWidth-1:0] FN_NOR  = 6'h27;
    localparam logic [CodeWidth-1:0] FN_NAND = 6'h28;
    localparam logic [CodeWidth-1:0] FN_SLT  = 6'h2A;

    localparam logic [DataWidth-1:0] MinSigned = 32'h8000_0000;

    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_OR,
        ALU_XOR,
        ALU_NOR,
        ALU_NAND,
        ALU_SLT,
        ALU_SLL,
        ALU_SRL,
        ALU_SRA,
        ALU_PASS_A,
        ALU_LUI
    } alu_op_t;

    typedef struct packed {
        logic    handled;
        alu_op_t op;
        logic    use_imm;
        logic    imm_sext;
        logic    ovf_en;
        logic    store_en;
        logic    dest_rd;
    } alu_ctrl_t;

endpackage

### rtl/core/risc_execute_alu.sv
// ----------------------------------------------------------------------------
// risc_execute_alu: execute-stage alu for a 32-bit risc subset
// two-register pipeline: input register, decode and alu, result register.
// one beat in, one beat out, one result per instruction. an accepted beat is
// held in the input register and then moves on into the result register,
// where out_valid presents it; a new beat is taken every cycle as long as
// the result side is not stalled. decode and the 32-bit adder lie in the
// single pass between the two registers. in_stall is raised only when
// both registers hold a beat and out_stall is high. unsupported opcode/funct
// pairs give handled low with all other result fields zero. store_data
// carries operand_b for loads and stores only. overflow reports signed
// overflow of add, sub, addi and address add.
// ----------------------------------------------------------------------------
module risc_execute_alu (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rea_pkg::CodeWidth-1:0]   opcode,
    input  logic [rea_pkg::CodeWidth-1:0]   funct,
    input  logic [rea_pkg::ShamtWidth-1:0]  shift_amount,
    input  logic [rea_pkg::ImmWidth-1:0]    immediate,
    input  logic [rea_pkg::DataWidth-1:0]   operand_a,
    input  logic [rea_pkg::DataWidth-1:0]   operand_b,
    input  logic [rea_pkg::RegIdxWidth-1:0] rt_index,
    input  logic [rea_pkg::RegIdxWidth-1:0] rd_index,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rea_pkg::DataWidth-1:0]   alu_result,
    output logic [rea_pkg::RegIdxWidth-1:0] dest_reg,
    output logic [rea_pkg::DataWidth-1:0]   store_data,
    output logic                            overflow,
    output logic                            handled
);
    import rea_pkg::*;

    // input register
    logic                   in_vld_reg;
    logic [CodeWidth-1:0]   opcode_reg;
    logic [CodeWidth-1:0]   funct_reg;
    logic [ShamtWidth-1:0]  shamt_reg;
    logic [ImmWidth-1:0]    imm_reg;
    logic [DataWidth-1:0]   opa_reg;
    logic [DataWidth-1:0]   opb_reg;
    logic [RegIdxWidth-1:0] rt_reg;
    logic [RegIdxWidth-1:0] rd_reg;

    // result register
    logic                   out_vld_reg;
    logic [DataWidth-1:0]   result_reg;
    logic [RegIdxWidth-1:0] dest_reg_q_reg;
    logic [DataWidth-1:0]   store_reg;
    logic                   ovf_reg;
    logic                   handled_reg;

    // combinational results of the alu
    alu_ctrl_t              ctrl;
    logic [DataWidth-1:0]   result_next;
    logic [RegIdxWidth-1:0] dest_next;
    logic [DataWidth-1:0]   store_next;
    logic                   ovf_next;
    logic                   handled_next;

    logic                   out_load;
    logic                   in_load;

    // result register can take a beat when empty or being drained
    assign out_load = !out_vld_reg || !out_stall;
    // input register can take a beat when empty or moving forward
    assign in_load  = !in_vld_reg || out_load;
    assign in_stall = !in_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_vld_reg <= in_valid;
            end
            if (out_load)
            begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    // payload of the input register
    always_ff @(posedge clk)
    begin
        if (in_load && in_valid)
        begin
            opcode_reg <= opcode;
            funct_reg  <= funct;
            shamt_reg  <= shift_amount;
            imm_reg    <= immediate;
            opa_reg    <= operand_a;
            opb_reg    <= operand_b;
            rt_reg     <= rt_index;
            rd_reg     <= rd_index;
        end
    end

    rea_decode u_decode (
        .opcode (opcode_reg),
        .funct  (funct_reg),
        .ctrl   (ctrl)
    );

    rea_exec u_exec (
        .ctrl         (ctrl),
        .shift_amount (shamt_reg),
        .immediate    (imm_reg),
        .operand_a    (opa_reg),
        .operand_b    (opb_reg),
        .rt_index     (rt_reg),
        .rd_index     (rd_reg),
        .alu_result   (result_next),
        .dest_reg     (dest_next),
        .store_data   (store_next),
        .overflow     (ovf_next),
        .handled      (handled_next)
    );

    // payload of the result register
    always_ff @(posedge clk)
    begin
        if (out_load && in_vld_reg)
        begin
            result_reg     <= result_next;
            dest_reg_q_reg <= dest_next;
            store_reg      <= store_next;
            ovf_reg        <= ovf_next;
            handled_reg    <= handled_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign alu_result = result_reg;
    assign dest_reg   = dest_reg_q_reg;
    assign store_data = store_reg;
    assign overflow   = ovf_reg;
    assign handled    = handled_reg;

endmodule

### rtl/core/rea_decode.sv
// ----------------------------------------------------------------------------
// rea_decode: instruction decode
// maps opcode and funct onto the alu control word
// ----------------------------------------------------------------------------
module rea_decode (
    input  logic [rea_pkg::CodeWidth-1:0] opcode,
    input  logic [rea_pkg::CodeWidth-1:0] funct,
    output rea_pkg::alu_ctrl_t            ctrl
);
    import rea_pkg::*;

    always_comb
    begin
        ctrl          = '0;
        ctrl.handled  = 1'b1;
        ctrl.op       = ALU_ADD;
        if (opcode == OP_RTYPE)
        begin
            ctrl.dest_rd = 1'b1;
            unique case (funct)
                FN_ADD:
                begin
                    ctrl.op     = ALU_ADD;
                    ctrl.ovf_en = 1'b1;
                end
                FN_SUB:
                begin
                    ctrl.op     = ALU_SUB;
                    ctrl.ovf_en = 1'b1;
                end
                FN_AND:  ctrl.op = ALU_AND;
                FN_OR:   ctrl.op = ALU_OR;
                FN_XOR:  ctrl.op = ALU_XOR;
                FN_NOR:  ctrl.op = ALU_NOR;
                FN_NAND: ctrl.op = ALU_NAND;
                FN_SLT:  ctrl.op = ALU_SLT;
                FN_SLL:  ctrl.op = ALU_SLL;
                FN_SRL:  ctrl.op = ALU_SRL;
                FN_SRA:  ctrl.op = ALU_SRA;
                FN_JR:   ctrl.op = ALU_PASS_A;
                default: ctrl.handled = 1'b0;
            endcase
        end
        else
        begin
            ctrl.use_imm = 1'b1;
            unique case (opcode)
                OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW:
                begin
                    ctrl.op       = ALU_ADD;
                    ctrl.imm_sext = 1'b1;
                    ctrl.ovf_en   = 1'b1;
                    ctrl.store_en = 1'b1;
                end
                OP_ADDI:
                begin
                    ctrl.op       = ALU_ADD;
                    ctrl.imm_sext = 1'b1;
                    ctrl.ovf_en   = 1'b1;
                end
                OP_ANDI: ctrl.op = ALU_AND;
                OP_ORI:  ctrl.op = ALU_OR;
                OP_NORI: ctrl.op = ALU_NOR;
                OP_SLTI:
                begin
                    ctrl.op       = ALU_SLT;
                    ctrl.imm_sext = 1'b1;
                end
                OP_LUI:  ctrl.op = ALU_LUI;
                default: ctrl.handled = 1'b0;
            endcase
        end
    end

endmodule

### rtl/core/rea_exec.sv
// ----------------------------------------------------------------------------
// rea_exec: alu datapath
// operand select, add/sub with overflow, logic, compare and shifts
// ----------------------------------------------------------------------------
module rea_exec (
    input  rea_pkg::alu_ctrl_t              ctrl,
    input  logic [rea_pkg::ShamtWidth-1:0]  shift_amount,
    input  logic [rea_pkg::ImmWidth-1:0]    immediate,
    input  logic [rea_pkg::DataWidth-1:0]   operand_a,
    input  logic [rea_pkg::DataWidth-1:0]   operand_b,
    input  logic [rea_pkg::RegIdxWidth-1:0] rt_index,
    input  logic [rea_pkg::RegIdxWidth-1:0] rd_index,
    output logic [rea_pkg::DataWidth-1:0]   alu_result,
    output logic [rea_pkg::RegIdxWidth-1:0] dest_reg,
    output logic [rea_pkg::DataWidth-1:0]   store_data,
    output logic                            overflow,
    output logic                            handled
);
    import rea_pkg::*;

    logic [DataWidth-1:0] imm_ext;
    logic [DataWidth-1:0] src_b;
    logic [DataWidth-1:0] add_b;
    logic [DataWidth-1:0] sum;
    logic                 add_ovf;
    logic                 lt;
    logic [DataWidth-1:0] res;

    always_comb
    begin
        if (ctrl.imm_sext)
        begin
            imm_ext = {{(DataWidth-ImmWidth){immediate[ImmWidth-1]}}, immediate};
        end
        else
        begin
            imm_ext = {{(DataWidth-ImmWidth){1'b0}}, immediate};
        end
        src_b = ctrl.use_imm ? imm_ext : operand_b;
    end

    // subtract as add of the two's complement
    assign add_b   = (ctrl.op == ALU_SUB) ? (~src_b + 32'd1) : src_b;
    assign sum     = operand_a + add_b;
    assign add_ovf = (operand_a[DataWidth-1] == add_b[DataWidth-1])
                     && (operand_a[DataWidth-1] != sum[DataWidth-1]);
    assign lt      = $signed(operand_a) < $signed(src_b);

    always_comb
    begin
        unique case (ctrl.op)
            ALU_ADD, ALU_SUB: res = sum;
            ALU_AND:    res = operand_a & src_b;
            ALU_OR:     res = operand_a | src_b;
            ALU_XOR:    res = operand_a ^ src_b;
            ALU_NOR:    res = ~(operand_a | src_b);
            ALU_NAND:   res = ~(operand_a & src_b);
            ALU_SLT:    res = {{(DataWidth-1){1'b0}}, lt};
            ALU_SLL:    res = operand_b << shift_amount;
            ALU_SRL:    res = operand_b >> shift_amount;
            ALU_SRA:    res = $unsigned($signed(operand_b) >>> shift_amount);
            ALU_PASS_A: res = operand_a;
            ALU_LUI:    res = {immediate, {(DataWidth-ImmWidth){1'b0}}};
            default:    res = '0;
        endcase
    end

    always_comb
    begin
        handled = ctrl.handled;
        if (ctrl.handled)
        begin
            alu_result = res;
            dest_reg   = ctrl.dest_rd ? rd_index : rt_index;
            store_data = ctrl.store_en ? operand_b : '0;
            // negating the most negative value always counts as overflow
            overflow   = ctrl.ovf_en && (add_ovf
                         || ((ctrl.op == ALU_SUB) && (operand_b == MinSigned)));
        end
        else
        begin
            alu_result = '0;
            dest_reg   = '0;
            store_data = '0;
            overflow   = 1'b0;
        end
    end

endmodule

### rtl/core/rea_checker.sv
// ----------------------------------------------------------------------------
// rea_checker: port-level checks for the execute-stage alu
// watches the handshakes and the result fields, bound to the top level
// ----------------------------------------------------------------------------
module rea_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [rea_pkg::DataWidth-1:0]   alu_result,
    input logic [rea_pkg::RegIdxWidth-1:0] dest_reg,
    input logic [rea_pkg::DataWidth-1:0]   store_data,
    input logic                            overflow,
    input logic                            handled
);
    import rea_pkg::*;

    // a stalled result beat stays and holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(alu_result)
            && $stable(dest_reg) && $stable(store_data)
            && $stable(overflow) && $stable(handled))
        else $error("stalled result beat changed");

    // input side only backs up when the result side is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // unsupported operations give all-zero result fields
    a_unhandled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !handled |-> alu_result == '0 && dest_reg == '0
            && store_data == '0 && !overflow)
        else $error("unhandled operation with nonzero result");

    // overflow only ever accompanies a supported operation
    a_ovf_handled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> handled)
        else $error("overflow on unhandled operation");

endmodule

bind risc_execute_alu rea_checker u_rea_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .alu_result (alu_result),
    .dest_reg   (dest_reg),
    .store_data (store_data),
    .overflow   (overflow),
    .handled    (handled)
);

### bench/risc_execute_alu_tb.sv
// ----------------------------------------------------------------------------
// risc_execute_alu_tb: self-checking bench for the execute-stage alu
// drives decoded instruction beats through the valid/stall input channel,
// predicts every result beat in place and compares it field by field at the
// output channel. a directed table covers every operation, the immediate
// extension rules, overflow corners and unsupported codes. a random run
// follows with random gaps on the sender and random stalls on the receiver,
// and includes one long receiver hold that backs the pipe up into in_stall.
// ----------------------------------------------------------------------------
module risc_execute_alu_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rea_pkg::*;

    // one instruction beat as presented on the input channel
    typedef struct packed {
        logic [CodeWidth-1:0]   opcode;
        logic [CodeWidth-1:0]   funct;
        logic [ShamtWidth-1:0]  shamt;
        logic [ImmWidth-1:0]    imm;
        logic [DataWidth-1:0]   a;
        logic [DataWidth-1:0]   b;
        logic [RegIdxWidth-1:0] rt;
        logic [RegIdxWidth-1:0] rd;
    } instr_beat_t;

    // one result beat as seen on the output channel
    typedef struct packed {
        logic [DataWidth-1:0]   value;
        logic [RegIdxWidth-1:0] dest;
        logic [DataWidth-1:0]   store;
        logic                   ovf;
        logic                   ok;
    } alu_beat_t;

    // directed row: the expectation is typed in only where it is obvious
    typedef struct {
        instr_beat_t ib;
        bit          typed;
        alu_beat_t   want;
    } stim_row_t;

    localparam int unsigned RandomBeats = 1650;
    localparam int unsigned HoldCycles = 60;
    localparam alu_beat_t NoResult = '0;

    // supported codes, picked from at random
    localparam logic [CodeWidth-1:0] RtypeFuncts [12] = '{
        FN_ADD, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_NOR,
        FN_NAND, FN_SLT, FN_SLL, FN_SRL, FN_SRA, FN_JR
    };
    localparam logic [CodeWidth-1:0] ItypeOpcodes [14] = '{
        OP_ADDI, OP_SLTI, OP_ANDI, OP_ORI, OP_NORI, OP_LUI, OP_LB,
        OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW
    };

    logic clk = 1'b0;
    logic rst_n;

    logic                   in_valid;
    logic                   in_stall;
    logic [CodeWidth-1:0]   opcode;
    logic [CodeWidth-1:0]   funct;
    logic [ShamtWidth-1:0]  shift_amount;
    logic [ImmWidth-1:0]    immediate;
    logic [DataWidth-1:0]   operand_a;
    logic [DataWidth-1:0]   operand_b;
    logic [RegIdxWidth-1:0] rt_index;
    logic [RegIdxWidth-1:0] rd_index;
    logic                   out_valid;
    logic                   out_stall;
    logic [DataWidth-1:0]   alu_result;
    logic [RegIdxWidth-1:0] dest_reg;
    logic [DataWidth-1:0]   store_data;
    logic                   overflow;
    logic                   handled;

    // results still owed by the block, oldest first
    alu_beat_t   owed_results[$];
    stim_row_t   directed_rows[$];

    int unsigned n_errors = 0;
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_ovf = 0;
    int unsigned n_unhandled = 0;
    int unsigned n_in_stalled = 0;
    bit          squeeze = 1'b0;
    bit          hold_done = 1'b0;

    risc_execute_alu dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .funct        (funct),
        .shift_amount (shift_amount),
        .immediate    (immediate),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .rt_index     (rt_index),
        .rd_index     (rd_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .alu_result   (alu_result),
        .dest_reg     (dest_reg),
        .store_data   (store_data),
        .overflow     (overflow),
        .handled      (handled)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // safety net in case the pipe hangs
    initial
    begin
        #1_000_000;
        $display("timeout with %0d results still owed", owed_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // signed overflow of a 32-bit add: same input signs, different sum sign
    function automatic logic add_overflows(input logic [DataWidth-1:0] x,
                                           input logic [DataWidth-1:0] y);
        logic [DataWidth-1:0] s;
        s = x + y;
        return (x[DataWidth-1] == y[DataWidth-1]) && (s[DataWidth-1] != x[DataWidth-1]);
    endfunction

    function automatic alu_beat_t alu_predict(input instr_beat_t ib);
        alu_beat_t            r;
        logic [DataWidth-1:0] sext_imm;
        logic [DataWidth-1:0] zext_imm;
        logic [DataWidth-1:0] neg_b;
        r = '0;
        r.ok = 1'b1;
        sext_imm = {{(DataWidth-ImmWidth){ib.imm[ImmWidth-1]}}, ib.imm};
        zext_imm = {{(DataWidth-ImmWidth){1'b0}}, ib.imm};
        neg_b = ~ib.b + 32'd1;
        if (ib.opcode == OP_RTYPE)
        begin
            r.dest = ib.rd;
            case (ib.funct)
                FN_ADD:
                begin
                    r.value = ib.a + ib.b;
                    r.ovf = add_overflows(ib.a, ib.b);
                end
                FN_SUB:
                begin
                    // the most negative subtrahend always flags
                    r.value = ib.a + neg_b;
                    r.ovf = add_overflows(ib.a, neg_b) || (ib.b == MinSigned);
                end
                FN_AND:  r.value = ib.a & ib.b;
                FN_OR:   r.value = ib.a | ib.b;
                FN_XOR:  r.value = ib.a ^ ib.b;
                FN_NOR:  r.value = ~(ib.a | ib.b);
                FN_NAND: r.value = ~(ib.a & ib.b);
                FN_SLT:  r.value = ($signed(ib.a) < $signed(ib.b)) ? 32'd1 : 32'd0;
                FN_SLL:  r.value = ib.b << ib.shamt;
                FN_SRL:  r.value = ib.b >> ib.shamt;
                FN_SRA:  r.value = $signed(ib.b) >>> ib.shamt;
                FN_JR:   r.value = ib.a;
                default: r.ok = 1'b0;
            endcase
        end
        else
        begin
            r.dest = ib.rt;
            case (ib.opcode)
                OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW:
                begin
                    r.value = ib.a + sext_imm;
                    r.ovf = add_overflows(ib.a, sext_imm);
                    r.store = ib.b;
                end
                OP_ADDI:
                begin
                    r.value = ib.a + sext_imm;
                    r.ovf = add_overflows(ib.a, sext_imm);
                end
                OP_ANDI: r.value = ib.a & zext_imm;
                OP_ORI:  r.value = ib.a | zext_imm;
                OP_NORI: r.value = ~(ib.a | zext_imm);
                OP_SLTI: r.value = ($signed(ib.a) < $signed(sext_imm)) ? 32'd1 : 32'd0;
                OP_LUI:  r.value = {ib.imm, 16'h0000};
                default: r.ok = 1'b0;
            endcase
        end
        // unsupported codes clear every field
        if (!r.ok)
            r = '0;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic instr_beat_t mk_instr(input logic [CodeWidth-1:0] op,
                                             input logic [CodeWidth-1:0] fn,
                                             input logic [ShamtWidth-1:0] sh,
                                             input logic [ImmWidth-1:0] imm,
                                             input logic [DataWidth-1:0] a,
                                             input logic [DataWidth-1:0] b,
                                             input logic [RegIdxWidth-1:0] rt,
                                             input logic [RegIdxWidth-1:0] rd);
        instr_beat_t ib;
        ib.opcode = op;
        ib.funct = fn;
        ib.shamt = sh;
        ib.imm = imm;
        ib.a = a;
        ib.b = b;
        ib.rt = rt;
        ib.rd = rd;
        return ib;
    endfunction

    // operands lean on the sign and carry corners
    function automatic logic [DataWidth-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return MinSigned;
            4:       return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [ImmWidth-1:0] pick_imm();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return 16'hFFFF;
            default: return ImmWidth'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // present one beat, hold it until accepted, then record what it owes
    task automatic send_instr(input instr_beat_t ib, input alu_beat_t want);
        int unsigned gap;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (squeeze || r < 55)
            gap = 0;
        else if (r < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 20);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= ib.opcode;
        funct        <= ib.funct;
        shift_amount <= ib.shamt;
        immediate    <= ib.imm;
        operand_a    <= ib.a;
        operand_b    <= ib.b;
        rt_index     <= ib.rt;
        rd_index     <= ib.rd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        owed_results.push_back(want);
        n_sent++;
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        n_errors++;
    endtask

    // ------------------------------------------------------------------------
    // sender: reset, directed table, random run, drain
    // ------------------------------------------------------------------------
    initial
    begin
        instr_beat_t ib;
        int unsigned kind;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        opcode       <= '0;
        funct        <= '0;
        shift_amount <= '0;
        immediate    <= '0;
        operand_a    <= '0;
        operand_b    <= '0;
        rt_index     <= '0;
        rd_index     <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // unsupported codes: everything reads zero
        directed_rows.push_back('{mk_instr(OP_RTYPE, 6'h3F, 5'd7, 16'h1234,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 5'd31), 1'b1, NoResult});
        directed_rows.push_back('{mk_instr(6'h3F, FN_ADD, 5'd0, 16'hFFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 5'd31), 1'b1, NoResult});
        // add overflow at the positive edge
        directed_rows.push_back('{mk_instr(OP_RTYPE, FN_ADD, 5'd0, 16'h0,
            32'h7FFF_FFFF, 32'h0000_0001, 5'd3, 5'd1), 1'b1,
            alu_beat_t'{32'h8000_0000, 5'd1, 32'h0, 1'b1, 1'b1}});
        // most negative subtrahend flags even without a true overflow
        directed_rows.push_back('{mk_instr(OP_RTYPE, FN_SUB, 5'd0, 16'h0,
            32'hFFFF_FFFF, MinSigned, 5'd0, 5'd31), 1'b1,
            alu_beat_t'{32'h7FFF_FFFF, 5'd31, 32'h0, 1'b1, 1'b1}});
        directed_rows.push_back('{mk_instr(OP_RTYPE, FN_SUB, 5'd0, 16'h0,
            MinSigned, 32'h0000_0001, 5'd0, 5'd2), 1'b0, NoResult});
        directed_rows.push_back('{mk_instr(OP_RTYPE, FN_AND, 5'd0, 16'h0,
            32'hF0F0_F0F0, 32'hFF00_FF00, 5'd0, 5'd4), 1'b0, NoResult});
        directed_rows.push_back('{mk_instr(OP_RTYPE, FN_OR, 5'd0, 16'h0,
            32'hF0F0_F0F0, 32'h0F0F_0000, 5'd0, 5'd5), 1'b0, NoResult});
        directed_rows.push_back('{mk_instr(OP_RTYPE, FN_XOR, 5'd0, 16'h0,
            32'hAAAA_5555, 32'hFFFF_0000, 5'd0, 5'd6), 1'b0, NoResult});
        directed_rows.push_back('{mk_instr(OP_RTYPE, FN_NOR, 5'd0, 16'h0,
            32'h0000_0000, 32'h0000_0000, 5'd0, 5'd7), 1'b0, NoResult});
        directed_rows.push_back('{mk_instr(OP_RTYPE, FN_NAND, 5'd0, 16'h0,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 5'd8), 1'b0, NoResult});
        directed_rows.push_back('{mk_instr(OP_RTYPE, FN_SLT, 5'd0, 16'h0,
            MinSigned, 32'h7FFF_FFFF, 5'd0, 5'd9), 1'b0, NoResult});
        // shift extremes
        directed_rows.push_back('{mk_instr(OP_RTYPE, FN_SLL, 5'd31, 16'h0,
            32'h0, 32'hFFFF_FFFF, 5'd0, 5'd10), 1'b1,
            alu_beat_t'{32'h8000_0000, 5'd10, 32'h0, 1'b0, 1'b1}});
        directed_rows.push_back('{mk_instr(OP_RTYPE, FN_SRL, 5'd31, 16'h0,
            32'h0, 32'hFFFF_FFFF, 5'd0, 5'd11), 1'b1,
            alu_beat_t'{32'h0000_0001, 5'd11, 32'h0, 1'b0, 1'b1}});
        directed_rows.push_back('{mk_instr(OP_RTYPE, FN_SRA, 5'd31, 16'h0,
            32'h0, MinSigned, 5'd0, 5'd12), 1'b1,
            alu_beat_t'{32'hFFFF_FFFF, 5'd12, 32'h0, 1'b0, 1'b1}});
        directed_rows.push_back('{mk_instr(OP_RTYPE, FN_JR, 5'd0, 16'h0,
            32'hDEAD_BEEF, 32'h1234_5678, 5'd0, 5'd13), 1'b0, NoResult});
        // memory address add with sign-extended offset and store data
        directed_rows.push_back('{mk_instr(OP_LW, 6'h00, 5'd0, 16'hFFFF,
            32'hFFFF_FFFF, 32'hDEAD_BEEF, 5'd14, 5'd0), 1'b0, NoResult});
        directed_rows.push_back('{mk_instr(OP_SW, 6'h3F, 5'd0, 16'h7FFF,
            32'h7FFF_FFFF, 32'hCAFE_F00D, 5'd15, 5'd31), 1'b0, NoResult});
        directed_rows.push_back('{mk_instr(OP_ADDI, 6'h00, 5'd0, 16'h8000,
            MinSigned, 32'h0, 5'd16, 5'd0), 1'b0, NoResult});
        directed_rows.push_back('{mk_instr(OP_SLTI, 6'h00, 5'd0, 16'hFFFF,
            32'hFFFF_FFFE, 32'h0, 5'd17, 5'd0), 1'b0, NoResult});
        // zero-extended logic immediates
        directed_rows.push_back('{mk_instr(OP_ANDI, 6'h00, 5'd0, 16'h8000,
            32'hFFFF_FFFF, 32'h0, 5'd18, 5'd0), 1'b0, NoResult});
        directed_rows.push_back('{mk_instr(OP_ORI, 6'h00, 5'd0, 16'hFFFF,
            32'h0, 32'h0, 5'd19, 5'd0), 1'b0, NoResult});
        directed_rows.push_back('{mk_instr(OP_NORI, 6'h00, 5'd0, 16'h00FF,
            32'h0F00_0000, 32'h0, 5'd20, 5'd0), 1'b0, NoResult});
        directed_rows.push_back('{mk_instr(OP_LUI, 6'h00, 5'd0, 16'hFFFF,
            32'h1234_5678, 32'h0, 5'd31, 5'd0), 1'b1,
            alu_beat_t'{32'hFFFF_0000, 5'd31, 32'h0, 1'b0, 1'b1}});

        foreach (directed_rows[i])
            send_instr(directed_rows[i].ib,
                       directed_rows[i].typed ? directed_rows[i].want
                                              : alu_predict(directed_rows[i].ib));

        // random run: mostly supported codes with random content
        for (int unsigned n = 0; n < RandomBeats; n++)
        begin
            ib = mk_instr(CodeWidth'($urandom_range(0, 63)),
                          CodeWidth'($urandom_range(0, 63)),
                          ShamtWidth'($urandom_range(0, 31)), pick_imm(), pick_operand(),
                          pick_operand(), RegIdxWidth'($urandom_range(0, 31)),
                          RegIdxWidth'($urandom_range(0, 31)));
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                ib.opcode = OP_RTYPE;
                ib.funct = RtypeFuncts[$urandom_range(0, 11)];
            end
            else if (kind < 85)
                ib.opcode = ItypeOpcodes[$urandom_range(0, 13)];
            else if (kind < 92)
                ib.opcode = OP_RTYPE;
            send_instr(ib, alu_predict(ib));
        end
        in_valid <= 1'b0;

        // drain, then keep watching to catch any extra result beat
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("sent %0d instruction beats, checked %0d results (%0d overflow, %0d unsupported)",
                 n_sent, n_checked, n_ovf, n_unhandled);
        $display("long receiver hold %0s, input stalled for %0d cycles",
                 hold_done ? "done" : "not reached", n_in_stalled);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus one long hold to back the pipe up
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned r;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (!hold_done && n_checked >= 300)
            begin
                // sender runs back to back while the output is held
                squeeze = 1'b1;
                out_stall <= 1'b1;
                for (int unsigned c = 0; c < HoldCycles; c++)
                    @(posedge clk);
                squeeze = 1'b0;
                hold_done = 1'b1;
            end
            else if (r < 30)
            begin
                // free-flowing stretch
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
            else if (r < 92)
            begin
                // short scattered stalls
                repeat ($urandom_range(1, 20))
                begin
                    out_stall <= ($urandom_range(0, 2) == 0);
                    @(posedge clk);
                end
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(8, 30)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // checker: compare each accepted result beat with the oldest owed one
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        alu_beat_t want;
        if (rst_n === 1'b1)
        begin
            if (in_valid && in_stall)
                n_in_stalled++;
            if (out_valid === 1'b1 && !out_stall)
            begin
                if (owed_results.size() == 0)
                    report_mismatch($sformatf("result beat with nothing owed, alu_result %h",
                                              alu_result));
                else
                begin
                    want = owed_results.pop_front();
                    n_checked++;
                    if (want.ovf)
                        n_ovf++;
                    if (!want.ok)
                        n_unhandled++;
                    if (alu_result !== want.value)
                        report_mismatch($sformatf("result %0d alu_result %h, expected %h",
                                                  n_checked, alu_result, want.value));
                    if (dest_reg !== want.dest)
                        report_mismatch($sformatf("result %0d dest_reg %0d, expected %0d",
                                                  n_checked, dest_reg, want.dest));
                    if (store_data !== want.store)
                        report_mismatch($sformatf("result %0d store_data %h, expected %h",
                                                  n_checked, store_data, want.store));
                    if (overflow !== want.ovf)
                        report_mismatch($sformatf("result %0d overflow %b, expected %b",
                                                  n_checked, overflow, want.ovf));
                    if (handled !== want.ok)
                        report_mismatch($sformatf("result %0d handled %b, expected %b",
                                                  n_checked, handled, want.ok));
                end
            end
        end
    end

endmodule

### risc_execute_alu.f
rtl/core/rea_pkg.sv
rtl/core/rea_decode.sv
rtl/core/rea_exec.sv
rtl/core/risc_execute_alu.sv
rtl/core/rea_checker.sv
bench/risc_execute_alu_tb.sv
